>>> sv/sbrp_pkg.sv
// ----------------------------------------------------------------------------
// sbrp_pkg
// Shared constants, types and helpers for the STUN binding reply parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sbrp_pkg;

    localparam logic [31:0] STUN_COOKIE  = 32'h2112_A442;
    localparam logic [15:0] TYPE_SUCCESS = 16'h0101;
    localparam logic [15:0] TYPE_ERROR   = 16'h0111;
    localparam logic [15:0] ATTR_XMAPPED = 16'h0020;
    localparam logic [15:0] ATTR_ERRCODE = 16'h0009;
    localparam logic [7:0]  FAMILY_V4    = 8'h01;
    localparam logic [16:0] POS_MAX      = 17'h1_FFFF;
    localparam logic [16:0] HDR_BYTES    = 17'd20;

    localparam int unsigned ID_HIGH_W = 32;
    localparam int unsigned ID_LOW_W  = 64;
    localparam int unsigned CFG_W     = 64;
    localparam int unsigned TDATA_W   = 64;
    localparam int unsigned TUSER_W   = 3;

    // Configuration register indexes
    typedef enum logic {
        CFG_ID_HIGH = 1'b0,
        CFG_ID_LOW  = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        KIND_NOT_STUN = 2'd0,
        KIND_OTHER    = 2'd1,
        KIND_SUCCESS  = 2'd2,
        KIND_ERROR    = 2'd3
    } t_kind;

    // One byte handed to the parse core
    typedef struct packed {
        logic       en;
        logic [7:0] data;
        logic       last;
    } t_byte_in;

    // One result item, fields in output order
    typedef struct packed {
        logic [9:0]  error_code;
        logic [15:0] mapped_port;
        logic [31:0] mapped_address;
        logic        address_valid;
        t_kind       reply_kind;
    } t_result;

    // ERROR-CODE value: class times 100 plus number
    function automatic logic [9:0] err_code(input logic [2:0] cls, input logic [7:0] num);
        logic [9:0] prod;
        prod = 10'(cls) * 10'd100;
        return prod + 10'(num);
    endfunction

endpackage

`default_nettype wire

>>> sv/sbrp_parse.sv
// ----------------------------------------------------------------------------
// sbrp_parse
// Per-message state of the parser: header checks, transaction ID compare and
// the attribute walk, one byte per enable. Builds the result on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sbrp_parse (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire  [sbrp_pkg::ID_HIGH_W-1:0]     i_id_high,
    input  wire  [sbrp_pkg::ID_LOW_W-1:0]      i_id_low,
    input  wire  sbrp_pkg::t_byte_in           i_byte,
    output sbrp_pkg::t_result                  o_result
);
    import sbrp_pkg::*;

    logic [16:0] r_pos, n_pos;
    logic        r_hdr_bad, n_hdr_bad;
    logic        r_id_mis, n_id_mis;
    logic [15:0] r_type, n_type;
    logic [15:0] r_decl, n_decl;
    logic [16:0] r_astart, n_astart;
    logic [15:0] r_atype, n_atype;
    logic [15:0] r_alen, n_alen;
    logic        r_stopped, n_stopped;
    logic [63:0] r_vshift, n_vshift;
    logic [48:0] r_found_addr, n_found_addr;
    logic [9:0]  r_found_err, n_found_err;

    logic [7:0]  w_b;
    logic [16:0] w_off;
    logic [16:0] w_q;
    logic [17:0] w_padded;
    logic [17:0] w_attr_end;
    logic [17:0] w_msg_end;
    logic [15:0] w_alen_new;
    logic [63:0] w_vs_new;
    logic [2:0]  w_idx_low;
    logic [1:0]  w_idx_w;
    logic [7:0]  w_cookie_b;
    logic [7:0]  w_idh_b;
    logic [7:0]  w_idl_b;
    t_kind       w_kind;
    logic        w_kept;

    assign w_b        = i_byte.data;
    assign w_idx_w    = ~r_pos[1:0];
    assign w_idx_low  = 3'(5'd19 - r_pos[4:0]);
    assign w_cookie_b = STUN_COOKIE[{w_idx_w, 3'b000} +: 8];
    assign w_idh_b    = i_id_high[{w_idx_w, 3'b000} +: 8];
    assign w_idl_b    = i_id_low[{w_idx_low, 3'b000} +: 8];
    assign w_off      = r_pos - r_astart;
    assign w_q        = w_off - 17'd4;
    assign w_alen_new = {r_alen[15:8], w_b};
    assign w_vs_new   = {r_vshift[55:0], w_b};
    assign w_padded   = (18'(r_alen) + 18'd3) & ~18'd3;
    assign w_attr_end = 18'(r_astart) + 18'd4 + 18'(w_alen_new);
    assign w_msg_end  = 18'(HDR_BYTES) + 18'(r_decl);

    // Update the message state for the current byte
    always_comb begin
        n_pos        = r_pos;
        n_hdr_bad    = r_hdr_bad;
        n_id_mis     = r_id_mis;
        n_type       = r_type;
        n_decl       = r_decl;
        n_astart     = r_astart;
        n_atype      = r_atype;
        n_alen       = r_alen;
        n_stopped    = r_stopped;
        n_vshift     = r_vshift;
        n_found_addr = r_found_addr;
        n_found_err  = r_found_err;

        if (r_pos == 17'd0) begin
            if (w_b[7:6] != 2'b00) n_hdr_bad = 1'b1;
            n_type = {w_b, 8'h00};
        end else if (r_pos == 17'd1) begin
            n_type[7:0] = w_b;
        end else if (r_pos == 17'd2) begin
            n_decl = {w_b, 8'h00};
        end else if (r_pos == 17'd3) begin
            n_decl[7:0] = w_b;
        end else if (r_pos < 17'd8) begin
            if (w_cookie_b != w_b) n_hdr_bad = 1'b1;
        end else if (r_pos < 17'd12) begin
            if (w_idh_b != w_b) n_id_mis = 1'b1;
        end else if (r_pos < HDR_BYTES) begin
            if (w_idl_b != w_b) n_id_mis = 1'b1;
        end else if (!r_stopped && r_pos >= r_astart) begin
            // Attribute walk
            case (w_off)
                17'd0: n_atype = {w_b, 8'h00};
                17'd1: n_atype[7:0] = w_b;
                17'd2: n_alen = {w_b, 8'h00};
                17'd3: begin
                    n_alen   = w_alen_new;
                    n_vshift = 64'd0;
                    if (w_attr_end > w_msg_end) begin
                        n_stopped = 1'b1;
                    end else if (w_alen_new == 16'd0) begin
                        n_astart = r_astart + 17'd4;
                    end
                end
                default: begin
                    if (w_q < 17'(r_alen)) begin
                        n_vshift = w_vs_new;
                        if (w_q == 17'd3 && r_atype == ATTR_ERRCODE && r_alen >= 16'd4) begin
                            n_found_err = err_code(w_vs_new[10:8], w_vs_new[7:0]);
                        end
                        if (w_q == 17'd7 && r_atype == ATTR_XMAPPED && r_alen >= 16'd8 &&
                            w_vs_new[55:48] == FAMILY_V4) begin
                            n_found_addr = {1'b1, w_vs_new[47:32] ^ STUN_COOKIE[31:16],
                                            w_vs_new[31:0] ^ STUN_COOKIE};
                        end
                    end
                    if (18'(w_q) == w_padded - 18'd1) begin
                        n_astart = 17'(18'(r_astart) + 18'd4 + w_padded);
                    end
                end
            endcase
        end

        // Saturating byte count
        if (r_pos != POS_MAX) n_pos = r_pos + 17'd1;
    end

    // Classify the message once the last byte is in
    always_comb begin
        if (n_pos < HDR_BYTES || n_hdr_bad || 18'(n_pos) != 18'(HDR_BYTES) + 18'(n_decl)) begin
            w_kind = KIND_NOT_STUN;
        end else if (n_id_mis || (n_type != TYPE_SUCCESS && n_type != TYPE_ERROR)) begin
            w_kind = KIND_OTHER;
        end else if (n_type == TYPE_SUCCESS) begin
            w_kind = KIND_SUCCESS;
        end else begin
            w_kind = KIND_ERROR;
        end
        w_kept = (w_kind == KIND_SUCCESS) || (w_kind == KIND_ERROR);

        o_result.reply_kind     = w_kind;
        o_result.address_valid  = w_kept ? n_found_addr[48]    : 1'b0;
        o_result.mapped_address = w_kept ? n_found_addr[31:0]  : 32'd0;
        o_result.mapped_port    = w_kept ? n_found_addr[47:32] : 16'd0;
        o_result.error_code     = w_kept ? n_found_err         : 10'd0;
    end

    // Hold state; advance on each byte, clear after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_byte.en && i_byte.last)) begin
            r_pos        <= 17'd0;
            r_hdr_bad    <= 1'b0;
            r_id_mis     <= 1'b0;
            r_type       <= 16'd0;
            r_decl       <= 16'd0;
            r_astart     <= HDR_BYTES;
            r_atype      <= 16'd0;
            r_alen       <= 16'd0;
            r_stopped    <= 1'b0;
            r_vshift     <= 64'd0;
            r_found_addr <= 49'd0;
            r_found_err  <= 10'd0;
        end else if (i_byte.en) begin
            r_pos        <= n_pos;
            r_hdr_bad    <= n_hdr_bad;
            r_id_mis     <= n_id_mis;
            r_type       <= n_type;
            r_decl       <= n_decl;
            r_astart     <= n_astart;
            r_atype      <= n_atype;
            r_alen       <= n_alen;
            r_stopped    <= n_stopped;
            r_vshift     <= n_vshift;
            r_found_addr <= n_found_addr;
            r_found_err  <= n_found_err;
        end
    end

endmodule

`default_nettype wire

>>> sv/stun_binding_reply_parser.sv
// ----------------------------------------------------------------------------
// stun_binding_reply_parser
// Parses a STUN binding reply byte by byte and reports one result per message.
// ----------------------------------------------------------------------------
// Bytes of one message enter on the slave stream in wire order, tlast on the
// final byte; one result transaction leaves on the master stream per message.
// The block takes one byte per cycle while the input is not stalled: each byte
// passes an input register and the header, ID and attribute-walk logic, and on
// the last byte the result is written to an output register, from which it is
// presented on the master stream. The input side only stalls when a last byte
// meets an output register still held by the downstream side.
// Program the expected transaction ID (index 0: bits 95..64, index 1: bits
// 63..0) while no message is in flight.
`default_nettype none

module stun_binding_reply_parser (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // Configuration write port
    input  wire                               i_cfg_we,
    input  wire                               i_cfg_addr,
    input  wire  [sbrp_pkg::CFG_W-1:0]        i_cfg_data,
    // Slave stream: tdata = data_byte[7:0]; tlast = last_byte
    input  wire                               i_s_tvalid,
    output logic                              o_s_tready,
    input  wire  [7:0]                        i_s_tdata,
    input  wire                               i_s_tlast,
    // Master stream: tdata = mapped_address[31:0], mapped_port[47:32],
    // error_code[57:48], zeros above
    output logic                              o_m_tvalid,
    input  wire                               i_m_tready,
    output logic [sbrp_pkg::TDATA_W-1:0]      o_m_tdata,
    // tuser = reply_kind[1:0], address_valid[2]
    output logic [sbrp_pkg::TUSER_W-1:0]      o_m_tuser
);
    import sbrp_pkg::*;

    logic [ID_HIGH_W-1:0] r_id_high;
    logic [ID_LOW_W-1:0]  r_id_low;
    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_last;
    logic                 r_out_valid;
    t_result              r_out;
    logic                 w_fire;
    t_byte_in             w_byte;
    t_result              w_result;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_high <= '0;
            r_id_low  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_addr))
                CFG_ID_HIGH: r_id_high <= i_cfg_data[ID_HIGH_W-1:0];
                CFG_ID_LOW:  r_id_low  <= i_cfg_data[ID_LOW_W-1:0];
                default:     r_id_low  <= r_id_low;
            endcase
        end
    end

    // Process the held byte unless its result has nowhere to go
    assign w_fire     = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    assign w_byte.en   = w_fire;
    assign w_byte.data = r_in_byte;
    assign w_byte.last = r_in_last;

    sbrp_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_id_high (r_id_high),
        .i_id_low  (r_id_low),
        .i_byte    (w_byte),
        .o_result  (w_result)
    );

    // Output register: load on a last byte, drop when the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in_last) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b000000, r_out.error_code, r_out.mapped_port,
                         r_out.mapped_address};
    assign o_m_tuser  = {r_out.address_valid, r_out.reply_kind};

    // Checks
    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_body_never_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in_last) |-> o_s_tready)
        else $error("input stalled on a byte that gives no result");

    a_rejected_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (r_out.reply_kind == KIND_NOT_STUN || r_out.reply_kind == KIND_OTHER))
        |-> (r_out.address_valid == 1'b0 && r_out.mapped_address == 32'd0 &&
             r_out.mapped_port == 16'd0 && r_out.error_code == 10'd0))
        else $error("fields set on a rejected message");

    a_error_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_out.error_code <= 10'd955))
        else $error("error code out of range");

    a_result_loaded_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_last) |=> o_m_tvalid)
        else $error("last byte processed without a result");

endmodule

`default_nettype wire
